// ===== rtl/tpfl_pkg.sv =====
// Shared types and constants for the two-tier page free list.
// Holds result codes, request codes, field widths and the controller/datapath
// command and status structs. No dependencies.
package tpfl_pkg;

  // Field widths fixed by the request/result format
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned FAST_USE_W = 11;
  localparam int unsigned SLOW_USE_W = 13;

  // Request kind
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Page tier
  localparam logic TIER_FAST = 1'b0;
  localparam logic TIER_SLOW = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic    latch_req;
    logic    take_fast;
    logic    take_slow;
    logic    put_fast;
    logic    put_slow;
    logic    load_out;
    status_t status;
    logic    given_tier;
    logic    give_page;
  } tpfl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic req_kind;
    logic req_tier;
    logic fast_empty;
    logic fast_full;
    logic slow_empty;
    logic slow_full;
    logic out_busy;
  } tpfl_sts_t;

endpackage

// ===== rtl/two_tier_page_free_list_core.sv =====
// Two-tier page free list: fast and slow FIFO rings of free page indices.
// Input channel (in_valid/in_stall) carries one request: kind selects
// allocate or free; free_tier and free_index name the page being freed.
// Output channel (out_valid/out_stall) returns one result per request:
// status, the granted page (given_tier, given_index) and pages in use per tier.
// Allocate takes the oldest free fast page, else the oldest free slow page,
// else reports no page. Free appends to its tier's ring, or is rejected when
// that ring is already full.
// Each request goes through the controller steps accept, ring read/write
// (registered memory read) and result load; a new request is accepted only
// once the previous one has completed its result load.
// in_stall is high whenever a request is in flight. A stalled result holds in
// the output register; the next request may be accepted and processed behind
// it, and waits in the load step until the result is taken.
// Reset (rst, synchronous) restores both rings to all pages free in ascending
// order at once, through a fill mark per ring; no clearing pass is needed.
// Depends on tpfl_pkg, tpfl_ctrl, tpfl_datapath and tpfl_ring.
module two_tier_page_free_list_core
  import tpfl_pkg::*;
#(
  parameter int unsigned FAST_PAGES = 1024,
  parameter int unsigned SLOW_PAGES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic                  free_tier,
  input  logic [IDX_W-1:0]      free_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  given_tier,
  output logic [IDX_W-1:0]      given_index,
  output logic [FAST_USE_W-1:0] fast_in_use,
  output logic [SLOW_USE_W-1:0] slow_in_use
);

  tpfl_cmd_t cmd;
  tpfl_sts_t sts;

  // Sequence requests
  tpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Rings and result register
  tpfl_datapath #(
    .FAST_PAGES (FAST_PAGES),
    .SLOW_PAGES (SLOW_PAGES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .free_tier   (free_tier),
    .free_index  (free_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .given_tier  (given_tier),
    .given_index (given_index),
    .fast_in_use (fast_in_use),
    .slow_in_use (slow_in_use)
  );

endmodule

// ===== rtl/tpfl_ring.sv =====
// One tier's free ring: a FIFO of free page indices in a memory written at the tail and read at the head.
// Entries not yet written since reset read back as their own address.
// Depends on tpfl_pkg.
module tpfl_ring
  import tpfl_pkg::*;
#(
  parameter int unsigned PAGES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic                           put,
  input  logic [IDX_W-1:0]               put_data,
  output logic                           empty,
  output logic                           full,
  output logic [$clog2(PAGES+1)-1:0]     in_use,
  output logic [IDX_W-1:0]               rd_data
);

  localparam int unsigned AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned CW = $clog2(PAGES + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] PAGES_C = CW'(PAGES);
  localparam logic [SW-1:0] PAGES_S = SW'(PAGES);
  localparam logic [AW-1:0] LAST    = AW'(PAGES - 1);

  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    filled;
  logic [IDX_W-1:0] mem [PAGES];
  logic [IDX_W-1:0] rd_mem;
  logic [AW-1:0]    rd_head;
  logic             rd_filled;

  logic [SW-1:0]    tail_sum;
  logic [SW-1:0]    tail_wrap;
  logic [AW-1:0]    tail;

  // Tail is head plus count, folded once into the ring
  assign tail_sum  = SW'(head) + SW'(count);
  assign tail_wrap = (tail_sum >= PAGES_S) ? (tail_sum - PAGES_S) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];

  assign empty   = (count == '0);
  assign full    = (count == PAGES_C);
  assign in_use  = PAGES_C - count;
  assign rd_data = rd_filled ? rd_mem : IDX_W'(rd_head);

  // Advance head, count and the fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= PAGES_C;
      filled <= '0;
    end else if (take) begin
      head  <= (head == LAST) ? '0 : head + AW'(1);
      count <= count - CW'(1);
    end else if (put) begin
      count <= count + CW'(1);
      if (filled != PAGES_C) begin
        filled <= filled + CW'(1);
      end
    end
  end

  // Ring storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (put) begin
      mem[tail] <= put_data;
    end
    if (take) begin
      rd_mem    <= mem[head];
      rd_head   <= head;
      rd_filled <= (CW'(head) < filled);
    end
  end

  // Ring must never under- or overflow
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst) take |-> !empty)
    else $error("take from empty ring");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= PAGES_C)
    else $error("ring count above capacity");

endmodule

// ===== rtl/tpfl_datapath.sv =====
// Datapath: request latch, the fast and slow rings, and the result register.
// Driven by tpfl_ctrl commands. Depends on tpfl_pkg and tpfl_ring.
module tpfl_datapath
  import tpfl_pkg::*;
#(
  parameter int unsigned FAST_PAGES = 1024,
  parameter int unsigned SLOW_PAGES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tpfl_cmd_t             cmd,
  output tpfl_sts_t             sts,
  input  logic                  kind,
  input  logic                  free_tier,
  input  logic [IDX_W-1:0]      free_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic                  given_tier,
  output logic [IDX_W-1:0]      given_index,
  output logic [FAST_USE_W-1:0] fast_in_use,
  output logic [SLOW_USE_W-1:0] slow_in_use
);

  localparam int unsigned FCW = $clog2(FAST_PAGES + 1);
  localparam int unsigned SCW = $clog2(SLOW_PAGES + 1);

  logic             req_kind;
  logic             req_tier;
  logic [IDX_W-1:0] req_index;

  logic             fast_empty, fast_full, slow_empty, slow_full;
  logic [FCW-1:0]   fast_use;
  logic [SCW-1:0]   slow_use;
  logic [IDX_W-1:0] fast_rd, slow_rd;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_kind  <= kind;
      req_tier  <= free_tier;
      req_index <= free_index;
    end
  end

  tpfl_ring #(.PAGES(FAST_PAGES)) u_fast (
    .clk      (clk),
    .rst      (rst),
    .take     (cmd.take_fast),
    .put      (cmd.put_fast),
    .put_data (req_index),
    .empty    (fast_empty),
    .full     (fast_full),
    .in_use   (fast_use),
    .rd_data  (fast_rd)
  );

  tpfl_ring #(.PAGES(SLOW_PAGES)) u_slow (
    .clk      (clk),
    .rst      (rst),
    .take     (cmd.take_slow),
    .put      (cmd.put_slow),
    .put_data (req_index),
    .empty    (slow_empty),
    .full     (slow_full),
    .in_use   (slow_use),
    .rd_data  (slow_rd)
  );

  assign sts.req_kind   = req_kind;
  assign sts.req_tier   = req_tier;
  assign sts.fast_empty = fast_empty;
  assign sts.fast_full  = fast_full;
  assign sts.slow_empty = slow_empty;
  assign sts.slow_full  = slow_full;
  assign sts.out_busy   = out_valid && out_stall;

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, counts taken after the ring update
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= cmd.status;
      given_tier  <= cmd.give_page ? cmd.given_tier : TIER_FAST;
      if (!cmd.give_page) begin
        given_index <= '0;
      end else if (cmd.given_tier == TIER_SLOW) begin
        given_index <= slow_rd;
      end else begin
        given_index <= fast_rd;
      end
      fast_in_use <= FAST_USE_W'(fast_use);
      slow_in_use <= SLOW_USE_W'(slow_use);
    end
  end

endmodule

// ===== rtl/tpfl_ctrl.sv =====
// Controller: sequences each request through accept, ring operation and
// result load. Depends on tpfl_pkg.
module tpfl_ctrl
  import tpfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  tpfl_sts_t sts,
  output tpfl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  state_t  state;
  status_t res_status;
  logic    res_tier;
  logic    res_give;

  logic    is_exec;
  logic    is_alloc;
  logic    take_fast, take_slow, put_fast, put_slow;

  assign in_stall = (state != S_IDLE);
  assign is_exec  = (state == S_EXEC);
  assign is_alloc = (sts.req_kind == KIND_ALLOC);

  // Pick the ring operation: fast first on allocate, own tier on free
  assign take_fast = is_exec && is_alloc && !sts.fast_empty;
  assign take_slow = is_exec && is_alloc && sts.fast_empty && !sts.slow_empty;
  assign put_fast  = is_exec && !is_alloc && (sts.req_tier == TIER_FAST) && !sts.fast_full;
  assign put_slow  = is_exec && !is_alloc && (sts.req_tier == TIER_SLOW) && !sts.slow_full;

  assign cmd.latch_req  = in_valid && (state == S_IDLE);
  assign cmd.take_fast  = take_fast;
  assign cmd.take_slow  = take_slow;
  assign cmd.put_fast   = put_fast;
  assign cmd.put_slow   = put_slow;
  assign cmd.load_out   = (state == S_EMIT) && !sts.out_busy;
  assign cmd.status     = res_status;
  assign cmd.given_tier = res_tier;
  assign cmd.give_page  = res_give;

  // State and registered result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_tier   <= TIER_FAST;
      res_give   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_alloc) begin
            res_status <= (sts.fast_empty && sts.slow_empty) ? ST_EMPTY : ST_OK;
          end else if (put_fast || put_slow) begin
            res_status <= ST_OK;
          end else begin
            res_status <= ST_FULL;
          end
          res_tier <= take_slow ? TIER_SLOW : TIER_FAST;
          res_give <= take_fast || take_slow;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // At most one ring operation per request
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({take_fast, take_slow, put_fast, put_slow}))
    else $error("more than one ring operation");
  // Every executed request reaches the result stage next
  a_exec_emit: assert property (@(posedge clk) disable iff (rst)
    is_exec |=> (state == S_EMIT))
    else $error("request skipped result stage");
  // A page is handed out exactly when a take was issued
  a_give_take: assert property (@(posedge clk) disable iff (rst)
    is_exec |=> (res_give == $past(take_fast || take_slow)))
    else $error("page grant does not match ring take");

endmodule
